// ===== hw/rtl/lspe_pkg.sv =====
// ----------------------------------------------------------------------------
// LED strip pattern engine package
// Shared constants, mode codes, controller states and control structs.
// ----------------------------------------------------------------------------
`default_nettype none

package lspe_pkg;

	localparam int STRIP_LENGTH = 64;
	localparam int IDX_W        = 6;
	localparam int CNT_W        = 7;
	localparam int COLOR_W      = 24;
	localparam int TICK_W       = 16;

	localparam logic [COLOR_W-1:0] RACER_HEAD = 24'h782800;
	localparam logic [COLOR_W-1:0] RACER_TAIL = 24'h2800B4;

	typedef enum logic [2:0] {
		MODE_CLEAR        = 3'd0,
		MODE_FLASH        = 3'd1,
		MODE_SWEEP_ONCE   = 3'd2,
		MODE_SWEEP_CYCLE  = 3'd3,
		MODE_TRACER_ONCE  = 3'd4,
		MODE_TRACER_CYCLE = 3'd5,
		MODE_RACER        = 3'd6,
		MODE_ALL          = 3'd7
	} mode_t;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_PREP   = 6'b000010,
		ST_DRAW   = 6'b000100,
		ST_FINISH = 6'b001000,
		ST_EMIT   = 6'b010000,
		ST_RESP   = 6'b100000
	} state_t;

	typedef struct packed {
		logic set_apply;
		logic prep;
		logic draw;
		logic finish;
		logic emit;
		logic resp;
	} cmd_t;

	typedef struct packed {
		logic draw_done;
		logic emit_done;
		logic resp_done;
	} sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lspe_ctrl.sv =====
// ----------------------------------------------------------------------------
// LED strip pattern engine controller
// Sequences command handling and the prepare, draw, finish and emit phases.
// ----------------------------------------------------------------------------
`default_nettype none

module lspe_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire logic          opcode,
	input  wire lspe_pkg::sts_t sts,
	output lspe_pkg::cmd_t     cmd
);

	lspe_pkg::state_t state_q;
	lspe_pkg::state_t state_d;
	logic             in_xfer;

	assign s_tready = (state_q == lspe_pkg::ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;

	always_comb begin
		cmd           = '0;
		cmd.set_apply = in_xfer && opcode;
		cmd.prep      = (state_q == lspe_pkg::ST_PREP);
		cmd.draw      = (state_q == lspe_pkg::ST_DRAW);
		cmd.finish    = (state_q == lspe_pkg::ST_FINISH);
		cmd.emit      = (state_q == lspe_pkg::ST_EMIT);
		cmd.resp      = (state_q == lspe_pkg::ST_RESP);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			lspe_pkg::ST_IDLE: begin
				if (in_xfer) begin
					state_d = opcode ? lspe_pkg::ST_RESP : lspe_pkg::ST_PREP;
				end
			end
			lspe_pkg::ST_PREP:   state_d = lspe_pkg::ST_DRAW;
			lspe_pkg::ST_DRAW: begin
				if (sts.draw_done) begin
					state_d = lspe_pkg::ST_FINISH;
				end
			end
			lspe_pkg::ST_FINISH: state_d = lspe_pkg::ST_EMIT;
			lspe_pkg::ST_EMIT: begin
				if (sts.emit_done) begin
					state_d = lspe_pkg::ST_IDLE;
				end
			end
			lspe_pkg::ST_RESP: begin
				if (sts.resp_done) begin
					state_d = lspe_pkg::ST_IDLE;
				end
			end
			default: state_d = lspe_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lspe_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/lspe_dpath.sv =====
// ----------------------------------------------------------------------------
// LED strip pattern engine datapath
// Mode state, frame store with per-pixel valid bits and the output pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module lspe_dpath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire lspe_pkg::cmd_t                cmd,
	output lspe_pkg::sts_t                     sts,
	input  wire logic [2:0]                    pattern,
	input  wire logic [5:0]                    start_position,
	input  wire logic [7:0]                    red,
	input  wire logic [7:0]                    green,
	input  wire logic [7:0]                    blue,
	input  wire logic [5:0]                    run_length,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [31:0]                        m_tdata,
	output logic                               m_tuser,
	output logic                               m_tlast
);

	localparam int SL = lspe_pkg::STRIP_LENGTH;
	localparam int IW = lspe_pkg::IDX_W;
	localparam int CW = lspe_pkg::CNT_W;
	localparam int XW = lspe_pkg::COLOR_W;
	localparam int TW = lspe_pkg::TICK_W;

	function automatic logic [IW-1:0] wrap_idx(input logic [CW-1:0] v);
		logic [CW-1:0] r;
		r = (v >= CW'(SL)) ? (v - CW'(SL)) : v;
		return r[IW-1:0];
	endfunction

	function automatic logic [IW-1:0] reduce_idx(input logic [IW-1:0] v);
		logic [CW-1:0] r;
		r = {1'b0, v};
		for (int i = 0; i < 8; i++) begin
			if (r >= CW'(SL)) begin
				r = r - CW'(SL);
			end
		end
		return r[IW-1:0];
	endfunction

	function automatic logic [IW-1:0] step_idx(input logic [IW-1:0] v);
		return wrap_idx({1'b0, v} + CW'(1));
	endfunction

	function automatic logic [7:0] sweep_red(input logic [CW-1:0] k);
		logic [7:0] r;
		case (k)
			7'd0:    r = 8'd10;
			7'd1:    r = 8'd30;
			7'd2:    r = 8'd60;
			7'd3:    r = 8'd0;
			7'd4:    r = 8'd60;
			7'd5:    r = 8'd30;
			7'd6:    r = 8'd10;
			default: r = 8'd0;
		endcase
		return r;
	endfunction

	lspe_pkg::mode_t   mode_now_q;
	lspe_pkg::mode_t   mode_req_q;
	logic [IW-1:0]     pos_a_q;
	logic [IW-1:0]     pos_b_q;
	logic [IW-1:0]     lit_q;
	logic [TW-1:0]     tick_q;
	logic [XW-1:0]     color_q;
	logic [CW-1:0]     n_q;
	logic [CW-1:0]     k_q;
	logic              drew_q;
	logic              taken_q;
	logic [IW-1:0]     emit_idx_q;
	logic [SL-1:0]     pix_vld_q;
	logic [XW-1:0]     frame_mem [SL];

	logic              taken;
	logic              clr_all;
	logic              we;
	logic [IW-1:0]     waddr;
	logic [XW-1:0]     wdata;
	logic [IW-1:0]     sweep_pos;
	logic [XW-1:0]     sweep_color;
	logic [7:0]        sweep_blue;
	logic [IW-1:0]     pos_a_next;
	logic              advance;
	logic              rd_en;

	logic              vld_s1;
	logic              from_mem_s1;
	logic              pix_vld_s1;
	logic [IW-1:0]     idx_s1;
	logic              acc_s1;
	logic              last_s1;
	logic [XW-1:0]     rdata_s1;

	logic              out_vld_q;
	logic [29:0]       out_pix_q;
	logic              out_acc_q;
	logic              out_last_q;

	assign taken      = (lspe_pkg::mode_t'(pattern) != mode_req_q);
	assign pos_a_next = step_idx(pos_a_q);
	assign advance    = !out_vld_q || m_tready;
	assign rd_en      = cmd.emit && advance;

	assign sts.draw_done = (k_q == n_q);
	assign sts.emit_done = rd_en && (emit_idx_q == IW'(SL - 1));
	assign sts.resp_done = cmd.resp && advance;

	assign clr_all = (cmd.set_apply && taken)
		|| (cmd.prep && (mode_now_q == lspe_pkg::MODE_CLEAR
			|| ((mode_now_q == lspe_pkg::MODE_SWEEP_ONCE
				|| mode_now_q == lspe_pkg::MODE_SWEEP_CYCLE) && tick_q > TW'(3))
			|| mode_now_q == lspe_pkg::MODE_TRACER_ONCE
			|| mode_now_q == lspe_pkg::MODE_TRACER_CYCLE
			|| mode_now_q == lspe_pkg::MODE_RACER));

	always_comb begin
		sweep_blue = color_q[7:0];
		if (k_q == CW'(3)) begin
			sweep_blue = 8'd255;
		end else if (k_q == CW'(4)) begin
			sweep_blue = 8'd0;
		end
		sweep_pos   = pos_a_next;
		sweep_color = {sweep_red(k_q), color_q[15:8], sweep_blue};
	end

	always_comb begin
		we    = cmd.draw && !sts.draw_done;
		waddr = pos_a_q;
		wdata = color_q;
		case (mode_now_q)
			lspe_pkg::MODE_FLASH: begin
				waddr = pos_a_q;
			end
			lspe_pkg::MODE_SWEEP_ONCE, lspe_pkg::MODE_SWEEP_CYCLE: begin
				waddr = sweep_pos;
				wdata = sweep_color;
			end
			lspe_pkg::MODE_TRACER_ONCE, lspe_pkg::MODE_TRACER_CYCLE: begin
				waddr = wrap_idx({1'b0, pos_a_q} + k_q);
			end
			lspe_pkg::MODE_RACER: begin
				if (k_q < CW'(6)) begin
					waddr = wrap_idx({1'b0, pos_a_q} + k_q);
					wdata = lspe_pkg::RACER_HEAD;
				end else begin
					waddr = wrap_idx({1'b0, pos_b_q} + (k_q - CW'(6)));
					wdata = lspe_pkg::RACER_TAIL;
				end
			end
			lspe_pkg::MODE_ALL: begin
				waddr = k_q[IW-1:0];
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			frame_mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_s1 <= frame_mem[emit_idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_vld_q <= '0;
		end else if (clr_all) begin
			pix_vld_q <= '0;
		end else if (we) begin
			pix_vld_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_now_q <= lspe_pkg::MODE_CLEAR;
			mode_req_q <= lspe_pkg::MODE_CLEAR;
			pos_a_q    <= '0;
			pos_b_q    <= '0;
			lit_q      <= '0;
			tick_q     <= '0;
			color_q    <= '0;
			n_q        <= '0;
			k_q        <= '0;
			drew_q     <= 1'b0;
			taken_q    <= 1'b0;
			emit_idx_q <= '0;
		end else begin
			if (cmd.set_apply) begin
				taken_q <= taken;
				if (taken) begin
					mode_now_q <= lspe_pkg::mode_t'(pattern);
					mode_req_q <= lspe_pkg::mode_t'(pattern);
					color_q    <= {red, green, blue};
					pos_a_q    <= reduce_idx(start_position);
					pos_b_q    <= reduce_idx(start_position);
					lit_q      <= ({1'b0, run_length} > CW'(SL - 1))
						? IW'(SL - 1) : run_length;
					tick_q     <= '0;
				end
			end

			if (cmd.prep) begin
				k_q        <= '0;
				emit_idx_q <= '0;
				drew_q     <= 1'b0;
				n_q        <= '0;
				case (mode_now_q)
					lspe_pkg::MODE_FLASH: n_q <= CW'(1);
					lspe_pkg::MODE_SWEEP_ONCE, lspe_pkg::MODE_SWEEP_CYCLE: begin
						if (tick_q > TW'(3)) begin
							tick_q <= '0;
							n_q    <= CW'(7);
							drew_q <= 1'b1;
						end
					end
					lspe_pkg::MODE_TRACER_ONCE, lspe_pkg::MODE_TRACER_CYCLE: begin
						n_q <= {1'b0, lit_q};
					end
					lspe_pkg::MODE_RACER: begin
						n_q <= CW'(8);
						if (tick_q < TW'(2)) begin
							pos_a_q <= pos_a_next;
						end else if (tick_q == TW'(3)) begin
							tick_q <= '0;
						end
					end
					lspe_pkg::MODE_ALL: begin
						if (tick_q < TW'(2)) begin
							n_q <= CW'(SL);
						end
					end
					default: n_q <= '0;
				endcase
			end

			if (we) begin
				k_q <= k_q + CW'(1);
				if (mode_now_q == lspe_pkg::MODE_SWEEP_ONCE
					|| mode_now_q == lspe_pkg::MODE_SWEEP_CYCLE) begin
					pos_a_q <= sweep_pos;
					color_q <= sweep_color;
				end
			end

			if (cmd.finish) begin
				tick_q <= tick_q + TW'(1);
				case (mode_now_q)
					lspe_pkg::MODE_FLASH: begin
						if (tick_q > TW'(10)) begin
							mode_now_q <= lspe_pkg::MODE_CLEAR;
						end
					end
					lspe_pkg::MODE_SWEEP_ONCE: begin
						if (drew_q && ({1'b0, pos_a_q} > CW'(SL - 8))) begin
							mode_now_q <= lspe_pkg::MODE_CLEAR;
						end
					end
					lspe_pkg::MODE_TRACER_ONCE: begin
						pos_a_q <= pos_a_next;
						if ({1'b0, pos_a_next} > (CW'(SL - 1) - {1'b0, lit_q})) begin
							mode_now_q <= lspe_pkg::MODE_CLEAR;
						end
					end
					lspe_pkg::MODE_TRACER_CYCLE: begin
						pos_a_q <= pos_a_next;
					end
					lspe_pkg::MODE_RACER: begin
						pos_b_q <= step_idx(pos_b_q);
						color_q <= lspe_pkg::RACER_TAIL;
					end
					default: begin
					end
				endcase
			end

			if (rd_en) begin
				emit_idx_q <= emit_idx_q + IW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (advance) begin
			vld_s1 <= cmd.emit || cmd.resp;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			from_mem_s1 <= cmd.emit;
			pix_vld_s1  <= pix_vld_q[emit_idx_q];
			idx_s1      <= cmd.emit ? emit_idx_q : '0;
			acc_s1      <= cmd.resp && taken_q;
			last_s1     <= cmd.resp || (emit_idx_q == IW'(SL - 1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance) begin
			out_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_pix_q[IW-1:0] <= idx_s1;
			out_pix_q[29:6]   <= (from_mem_s1 && pix_vld_s1)
				? {rdata_s1[7:0], rdata_s1[15:8], rdata_s1[23:16]} : '0;
			out_acc_q         <= acc_s1;
			out_last_q        <= last_s1;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {2'b00, out_pix_q};
	assign m_tuser  = out_acc_q;
	assign m_tlast  = out_last_q;

endmodule

`default_nettype wire

// ===== hw/rtl/led_strip_pattern_engine.sv =====
// ----------------------------------------------------------------------------
// LED strip pattern engine
// Animates a 64-pixel RGB frame store; each tick emits the whole frame.
// ----------------------------------------------------------------------------
// Input channel s_*: s_tuser is the opcode (0 tick, 1 set pattern); s_tdata
// carries the pattern command fields. A set command yields one transfer with
// m_tuser high when the pattern was taken and m_tlast high. A tick yields 64
// pixel transfers in index order, m_tlast on the final one.
// Sequencing: a set command is taken and answered, then the input reopens. A
// tick steps through prepare, draw (one pixel per cycle, 0 to 64 pixels, set
// by the mode) and finish before the 64 frame reads, one per cycle unless the
// output stalls, through the single frame store read port, and then returns
// to idle to take the next item.
// One item is in work at a time; the two-stage output pipeline drains while
// the next item is accepted.
// Reset clears the mode state and the pixel valid bits, so the frame reads
// as all off; no clearing pass is needed. When m_tready is low with m_tvalid
// high, the output register and read stage hold and the frame reads pause.
// ----------------------------------------------------------------------------
`default_nettype none

module led_strip_pattern_engine (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,  // pattern, start_position, red, green, blue, run_length
	input  wire logic        s_tuser,  // opcode
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,  // pixel_index, pixel_red, pixel_green, pixel_blue
	output logic             m_tuser,  // accepted
	output logic             m_tlast
);

	lspe_pkg::cmd_t cmd;
	lspe_pkg::sts_t sts;

	lspe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.opcode   (s_tuser),
		.sts      (sts),
		.cmd      (cmd)
	);

	lspe_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.pattern        (s_tdata[2:0]),
		.start_position (s_tdata[8:3]),
		.red            (s_tdata[16:9]),
		.green          (s_tdata[24:17]),
		.blue           (s_tdata[32:25]),
		.run_length     (s_tdata[38:33]),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.m_tlast        (m_tlast)
	);

endmodule

`default_nettype wire
